// ===== rtl/kpow_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kpow_pkg
// Shared widths, register indexes, mode codes, state types and the
// request/response structs between the sequencer and the key engine.
// ----------------------------------------------------------------------------
package kpow_pkg;

  // Field widths fixed by the result format
  localparam int SUM_BITS      = 38;
  localparam int KEY_BITS      = 64;
  localparam int LEN_BITS      = 7;
  localparam int MODE_BITS     = 3;
  localparam int CFG_IDX_BITS  = 8;
  localparam int CFG_DATA_BITS = 8;

  // Configuration register indexes
  localparam logic [CFG_IDX_BITS-1:0] CFG_VECTOR_LENGTH = CFG_IDX_BITS'(0);
  localparam logic [CFG_IDX_BITS-1:0] CFG_DISTANCE_MODE = CFG_IDX_BITS'(1);

  // Register reset values
  localparam logic [LEN_BITS-1:0]  LEN_RESET  = LEN_BITS'(2);
  localparam logic [MODE_BITS-1:0] MODE_RESET = MODE_BITS'(1);

  // Distance mode codes; every code above the cube means fourth power
  localparam logic [MODE_BITS-1:0] MODE_ROOT   = MODE_BITS'(0);
  localparam logic [MODE_BITS-1:0] MODE_SUM    = MODE_BITS'(1);
  localparam logic [MODE_BITS-1:0] MODE_SQUARE = MODE_BITS'(2);
  localparam logic [MODE_BITS-1:0] MODE_CUBE   = MODE_BITS'(3);

  localparam logic [SUM_BITS-1:0] SUM_MASK = '1;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_ACCUM,
    ST_KEY
  } kpow_state_t;

  // Key engine states
  typedef enum logic [1:0] {
    KE_IDLE,
    KE_ROOT,
    KE_MUL,
    KE_DONE
  } kpow_eng_state_t;

  // Sequencer to engine
  typedef struct packed {
    logic start;
    logic ack;
  } kpow_eng_req_t;

  // Engine to sequencer
  typedef struct packed {
    logic                done;
    logic [KEY_BITS-1:0] key;
    logic [SUM_BITS-1:0] sqdist;
    logic                sat;
  } kpow_eng_res_t;

endpackage

// ===== rtl/kpow_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kpow_in_if
// Coordinate pair request channel with valid/ready handshake.
// ----------------------------------------------------------------------------
interface kpow_in_if #(
  parameter int COORD_BITS = 16
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] coord_a;
  logic signed [COORD_BITS-1:0] coord_b;

  modport source (output valid, output coord_a, output coord_b, input ready);
  modport sink   (input valid, input coord_a, input coord_b, output ready);
endinterface

// ===== rtl/kpow_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kpow_out_if
// Distance result channel with valid/ready handshake.
// ----------------------------------------------------------------------------
interface kpow_out_if;
  import kpow_pkg::*;

  logic                valid;
  logic                ready;
  logic [KEY_BITS-1:0] ordering_key;
  logic [SUM_BITS-1:0] squared_distance;
  logic                key_saturated;

  modport source (output valid, output ordering_key, output squared_distance,
                  output key_saturated, input ready);
  modport sink   (input valid, input ordering_key, input squared_distance,
                  input key_saturated, output ready);
endinterface

// ===== rtl/kpow_cfg_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kpow_cfg_if
// Register write channel: index and data with valid/ready handshake.
// ----------------------------------------------------------------------------
interface kpow_cfg_if;
  import kpow_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [CFG_IDX_BITS-1:0]  index;
  logic [CFG_DATA_BITS-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/kpow_addsub.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kpow_addsub
// Shared 64-bit adder/subtractor with carry out. Subtract gives carry high
// when a is not below b.
// ----------------------------------------------------------------------------
module kpow_addsub (
  input  logic [kpow_pkg::KEY_BITS-1:0] a,
  input  logic [kpow_pkg::KEY_BITS-1:0] b,
  input  logic                          sub,
  output logic [kpow_pkg::KEY_BITS-1:0] sum,
  output logic                          carry
);
  import kpow_pkg::*;

  logic [KEY_BITS-1:0] b_op;

  // Invert the second operand and inject the carry for subtraction
  assign b_op = sub ? ~b : b;
  assign {carry, sum} = {1'b0, a} + {1'b0, b_op} + {{KEY_BITS{1'b0}}, sub};

endmodule

// ===== rtl/kpow_keyeng.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kpow_keyeng
// Ordering key engine: the sum as it is, a bit-pair integer square root, or
// repeated shift-and-add saturating multiplies, all on one shared adder.
// ----------------------------------------------------------------------------
module kpow_keyeng (
  input  logic                          clk,
  input  logic                          rst_n,
  input  kpow_pkg::kpow_eng_req_t       req,
  input  logic [kpow_pkg::MODE_BITS-1:0] mode,
  input  logic [kpow_pkg::SUM_BITS-1:0]  sum_in,
  output kpow_pkg::kpow_eng_res_t       res
);
  import kpow_pkg::*;

  localparam int ITER_W   = $clog2(SUM_BITS);
  localparam int ROOT_TOP = ((SUM_BITS - 1) / 2) * 2;
  localparam logic [SUM_BITS-1:0] ROOT_BIT = {{(SUM_BITS-1){1'b0}}, 1'b1} << ROOT_TOP;
  localparam logic [ITER_W-1:0]   ITER_LAST = ITER_W'(SUM_BITS - 1);

  kpow_eng_state_t     state_r, state_nxt;
  logic [MODE_BITS-1:0] mode_r, mode_nxt;
  logic [SUM_BITS-1:0] sum_r, sum_nxt;
  logic [SUM_BITS-1:0] rem_r, rem_nxt;
  logic [SUM_BITS-1:0] root_r, root_nxt;
  logic [SUM_BITS-1:0] bit_r, bit_nxt;
  logic [ITER_W-1:0]   iter_r, iter_nxt;
  logic [KEY_BITS-1:0] prod_r, prod_nxt;
  logic [KEY_BITS-1:0] acc_r, acc_nxt;
  logic [1:0]          mul_left_r, mul_left_nxt;
  logic                ovf_r, ovf_nxt;
  logic                sat_r, sat_nxt;
  logic [KEY_BITS-1:0] key_r, key_nxt;

  logic [KEY_BITS-1:0] alu_a, alu_b, alu_sum;
  logic                alu_sub, alu_carry;
  logic [SUM_BITS-1:0] trial, root_new;
  logic                ovf_now, mul_last;

  // Shared arithmetic unit
  kpow_addsub u_alu (
    .a     (alu_a),
    .b     (alu_b),
    .sub   (alu_sub),
    .sum   (alu_sum),
    .carry (alu_carry)
  );

  // Operand selection for the shared unit
  always_comb begin
    trial   = root_r | bit_r;
    alu_a   = {acc_r[KEY_BITS-2:0], 1'b0};
    alu_b   = sum_r[iter_r] ? prod_r : '0;
    alu_sub = 1'b0;
    if (state_r == KE_ROOT) begin
      alu_a   = KEY_BITS'(rem_r);
      alu_b   = KEY_BITS'(trial);
      alu_sub = 1'b1;
    end
    root_new = alu_carry ? ((root_r >> 1) | bit_r) : (root_r >> 1);
    ovf_now  = ovf_r | acc_r[KEY_BITS-1] | alu_carry;
    mul_last = (iter_r == '0) && ((mul_left_r == 2'd1) || ovf_now);
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      KE_IDLE: begin
        if (req.start) begin
          case (mode)
            MODE_ROOT: state_nxt = KE_ROOT;
            MODE_SUM:  state_nxt = KE_DONE;
            default:   state_nxt = KE_MUL;
          endcase
        end
      end
      KE_ROOT: begin
        if (bit_r[0]) state_nxt = KE_DONE;
      end
      KE_MUL: begin
        if (mul_last) state_nxt = KE_DONE;
      end
      KE_DONE: begin
        if (req.ack) state_nxt = KE_IDLE;
      end
      default: state_nxt = KE_IDLE;
    endcase
  end

  // Datapath updates
  always_comb begin
    mode_nxt     = mode_r;
    sum_nxt      = sum_r;
    rem_nxt      = rem_r;
    root_nxt     = root_r;
    bit_nxt      = bit_r;
    iter_nxt     = iter_r;
    prod_nxt     = prod_r;
    acc_nxt      = acc_r;
    mul_left_nxt = mul_left_r;
    ovf_nxt      = ovf_r;
    sat_nxt      = sat_r;
    key_nxt      = key_r;
    case (state_r)
      KE_IDLE: begin
        if (req.start) begin
          mode_nxt = mode;
          sum_nxt  = sum_in;
          rem_nxt  = sum_in;
          root_nxt = '0;
          bit_nxt  = ROOT_BIT;
          iter_nxt = ITER_LAST;
          prod_nxt = KEY_BITS'(sum_in);
          acc_nxt  = '0;
          ovf_nxt  = 1'b0;
          sat_nxt  = 1'b0;
          key_nxt  = KEY_BITS'(sum_in);
          case (mode)
            MODE_CUBE: mul_left_nxt = 2'd2;
            default:   mul_left_nxt = (mode == MODE_SQUARE) ? 2'd1 : 2'd3;
          endcase
        end
      end
      KE_ROOT: begin
        // Take one result bit per cycle
        if (alu_carry) rem_nxt = alu_sum[SUM_BITS-1:0];
        root_nxt = root_new;
        bit_nxt  = bit_r >> 2;
        key_nxt  = KEY_BITS'(root_new);
      end
      KE_MUL: begin
        // Double and add, one multiplier bit per cycle, most significant first
        if (iter_r == '0) begin
          if (mul_last) begin
            key_nxt = ovf_now ? '1 : alu_sum;
            sat_nxt = ovf_now;
          end else begin
            prod_nxt     = alu_sum;
            acc_nxt      = '0;
            iter_nxt     = ITER_LAST;
            mul_left_nxt = mul_left_r - 2'd1;
            ovf_nxt      = 1'b0;
          end
        end else begin
          acc_nxt  = alu_sum;
          ovf_nxt  = ovf_now;
          iter_nxt = iter_r - 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= KE_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r     <= mode_nxt;
    sum_r      <= sum_nxt;
    rem_r      <= rem_nxt;
    root_r     <= root_nxt;
    bit_r      <= bit_nxt;
    iter_r     <= iter_nxt;
    prod_r     <= prod_nxt;
    acc_r      <= acc_nxt;
    mul_left_r <= mul_left_nxt;
    ovf_r      <= ovf_nxt;
    sat_r      <= sat_nxt;
    key_r      <= key_nxt;
  end

  assign res.done   = (state_r == KE_DONE);
  assign res.key    = key_r;
  assign res.sqdist = sum_r;
  assign res.sat    = sat_r;

  // Root walk keeps a single trial bit
  a_root_bit: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == KE_ROOT |-> $onehot(bit_r))
    else $error("root trial bit lost");

  // A clamped key is all ones
  a_sat_key: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == KE_DONE && sat_r |-> &key_r)
    else $error("saturated key not clamped");

  // Clamping only happens in power modes
  a_sat_mode: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == KE_DONE && sat_r |-> mode_r != MODE_ROOT && mode_r != MODE_SUM)
    else $error("saturation flagged outside power modes");

endmodule

// ===== rtl/squared_distance_power_kernel_core.sv =====
`timescale 1ns / 1ps
// A pair that does not close a vector is accepted, squared and accumulated.
// A closing pair goes on to the key engine: a pass-through in squared-sum mode, the root
// (19 result bits, one per cycle, then a hand-off state), or 1 to 3 shift-and-add
// multiplies for powers (ending early on overflow) and a hand-off state; then the output
// register. One request in flight; output register frees it.
// Reset (synchronous, rst_n low): sum and pair count cleared, length 2, mode 1, no result.
// ----------------------------------------------------------------------------
// squared_distance_power_kernel_core
// Accumulates squared coordinate differences over a vector and emits the
// squared distance with a mode-selected ordering key.
// ----------------------------------------------------------------------------
module squared_distance_power_kernel_core #(
  parameter int MAX_DIM    = 64,
  parameter int COORD_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  kpow_in_if.sink     in_chan,
  kpow_out_if.source  out_chan,
  kpow_cfg_if.sink    cfg_chan
);
  import kpow_pkg::*;

  localparam int MAG_W   = COORD_BITS + 1;
  localparam int SQ_W    = 2 * MAG_W;
  localparam int ADD_W   = ((SQ_W > SUM_BITS) ? SQ_W : SUM_BITS) + 1;
  localparam int LEN_MAX = (2 ** LEN_BITS) - 1;
  localparam int LEN_CAP_I = (MAX_DIM < LEN_MAX) ? MAX_DIM : LEN_MAX;
  localparam logic [LEN_BITS-1:0] LEN_CAP = LEN_BITS'(LEN_CAP_I);

  kpow_state_t          state_r, state_nxt;
  logic [LEN_BITS-1:0]  len_r;
  logic [MODE_BITS-1:0] mode_r;
  logic [LEN_BITS-1:0]  cnt_r, cnt_nxt;
  logic [SUM_BITS-1:0]  acc_r, acc_nxt;
  logic [MAG_W-1:0]     mag_r;
  logic [SQ_W-1:0]      sq_r;
  logic                 out_valid_r, out_valid_nxt;
  logic [KEY_BITS-1:0]  out_key_r;
  logic [SUM_BITS-1:0]  out_sqdist_r;
  logic                 out_sat_r;

  logic signed [COORD_BITS-1:0] coord_a_w, coord_b_w;
  logic [MAG_W-1:0]     diff_u, mag_nxt;
  logic [ADD_W-1:0]     sum_wide;
  logic [SUM_BITS-1:0]  sum_new;
  logic [LEN_BITS-1:0]  eff_len;
  logic [LEN_BITS:0]    cnt_inc;
  logic                 last_pair;
  logic                 in_take, load_out;
  kpow_eng_req_t        eng_req;
  kpow_eng_res_t        eng_res;

  assign coord_a_w = in_chan.coord_a;
  assign coord_b_w = in_chan.coord_b;
  assign in_take   = in_chan.valid & in_chan.ready;

  // Difference magnitude of the incoming pair
  always_comb begin
    diff_u  = MAG_W'($signed({coord_a_w[COORD_BITS-1], coord_a_w})
                   - $signed({coord_b_w[COORD_BITS-1], coord_b_w}));
    mag_nxt = diff_u[MAG_W-1] ? (~diff_u + 1'b1) : diff_u;
  end

  // Accumulate with saturation and check the vector end
  always_comb begin
    sum_wide = ADD_W'(acc_r) + ADD_W'(sq_r);
    sum_new  = (sum_wide > ADD_W'(SUM_MASK)) ? SUM_MASK : sum_wide[SUM_BITS-1:0];
    if (len_r == '0) begin
      eff_len = LEN_BITS'(1);
    end else if (len_r > LEN_CAP) begin
      eff_len = LEN_CAP;
    end else begin
      eff_len = len_r;
    end
    cnt_inc   = {1'b0, cnt_r} + 1'b1;
    last_pair = (cnt_inc >= {1'b0, eff_len});
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:   if (in_take) state_nxt = ST_SQUARE;
      ST_SQUARE: state_nxt = ST_ACCUM;
      ST_ACCUM:  state_nxt = last_pair ? ST_KEY : ST_IDLE;
      ST_KEY:    if (load_out) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_chan.ready = (state_r == ST_IDLE);
    eng_req.start = (state_r == ST_ACCUM) && last_pair;
    load_out      = (state_r == ST_KEY) && eng_res.done
                    && (!out_valid_r || out_chan.ready);
    eng_req.ack   = load_out;
  end

  // Running sum and pair count
  always_comb begin
    cnt_nxt = cnt_r;
    acc_nxt = acc_r;
    if (state_r == ST_ACCUM) begin
      if (last_pair) begin
        cnt_nxt = '0;
        acc_nxt = '0;
      end else begin
        cnt_nxt = cnt_inc[LEN_BITS-1:0];
        acc_nxt = sum_new;
      end
    end
  end

  assign out_valid_nxt = load_out | (out_valid_r & ~out_chan.ready);

  kpow_keyeng u_keyeng (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (eng_req),
    .mode   (mode_r),
    .sum_in (sum_new),
    .res    (eng_res)
  );

  // Control state and configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      acc_r       <= '0;
      out_valid_r <= 1'b0;
      len_r       <= LEN_RESET;
      mode_r      <= MODE_RESET;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      acc_r       <= acc_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_chan.valid && cfg_chan.ready) begin
        case (cfg_chan.index)
          CFG_VECTOR_LENGTH: len_r  <= cfg_chan.data[LEN_BITS-1:0];
          CFG_DISTANCE_MODE: mode_r <= cfg_chan.data[MODE_BITS-1:0];
          default: ;
        endcase
      end
    end
  end

  // Pair datapath and result register
  always_ff @(posedge clk) begin
    if (in_take) mag_r <= mag_nxt;
    if (state_r == ST_SQUARE) sq_r <= mag_r * mag_r;
    if (load_out) begin
      out_key_r    <= eng_res.key;
      out_sqdist_r <= eng_res.sqdist;
      out_sat_r    <= eng_res.sat;
    end
  end

  assign cfg_chan.ready            = 1'b1;
  assign out_chan.valid            = out_valid_r;
  assign out_chan.ordering_key     = out_key_r;
  assign out_chan.squared_distance = out_sqdist_r;
  assign out_chan.key_saturated    = out_sat_r;

  // A flagged result carries a clamped key
  a_out_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_sat_r |-> &out_key_r)
    else $error("saturated result without clamped key");

  // Vector state is cleared while the key is worked out
  a_key_clear: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_KEY |-> cnt_r == '0 && acc_r == '0)
    else $error("vector state not cleared for key");

  // The engine only finishes while the sequencer waits on it
  a_done_key: assert property (@(posedge clk) disable iff (!rst_n)
    eng_res.done |-> state_r == ST_KEY)
    else $error("engine result outside key phase");

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the squared distance power kernel. A directed
// table walks the field extremes, every distance mode and the corner cases
// of the vector length; random phases then mix register settings, vector
// lengths and coordinates under random back-pressure. Every result is
// compared with a local predictor of the accumulate-and-key behaviour.
// ----------------------------------------------------------------------------
module testbench;
  import kpow_pkg::*;

  localparam int MAX_DIM      = 64;
  localparam int COORD_BITS   = 16;
  localparam int RANDOM_ITEMS = 500;
  localparam int IDLE_PCT     = 8;
  localparam int DRAIN_GAP    = 8;
  localparam int SETTLE_GAP   = 150;
  localparam int STALL_LIMIT  = 2000;

  // Mode codes beyond the package set: fourth power and the spare codes
  localparam logic [MODE_BITS-1:0] MODE_POW4     = MODE_BITS'(4);
  localparam logic [MODE_BITS-1:0] MODE_SPARE_LO = MODE_BITS'(5);
  localparam logic [MODE_BITS-1:0] MODE_SPARE_HI = MODE_BITS'(7);

  // Register index with no register behind it
  localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE_IDX = CFG_IDX_BITS'(5);

  localparam logic signed [COORD_BITS-1:0] COORD_MIN = 16'sh8000;
  localparam logic signed [COORD_BITS-1:0] COORD_MAX = 16'sh7fff;

  localparam logic [SUM_BITS-1:0] EXT_SQ     = 38'd4294836225;
  localparam logic [KEY_BITS-1:0] EXT_SQ_KEY = 64'd4294836225;
  localparam logic [KEY_BITS-1:0] KEY_CLAMP  = '1;

  typedef struct packed {
    logic [KEY_BITS-1:0] key;
    logic [SUM_BITS-1:0] sqd;
    logic                sat;
  } dist_res_t;

  localparam dist_res_t NO_RESULT = '0;

  typedef enum logic {ROW_CFG, ROW_PAIR} row_kind_t;

  typedef struct {
    row_kind_t                     kind;
    logic [CFG_IDX_BITS-1:0]       idx;
    logic [CFG_DATA_BITS-1:0]      data;
    logic signed [COORD_BITS-1:0]  a;
    logic signed [COORD_BITS-1:0]  b;
    bit                            typed;
    dist_res_t                     res;
  } stim_row_t;

  // Directed plan: typed results only where they are plain to see
  stim_row_t directed_plan [35] = '{
    '{ROW_PAIR, '0, '0, 16'sd0, 16'sd0, 1'b0, NO_RESULT},
    '{ROW_PAIR, '0, '0, 16'sd0, 16'sd0, 1'b1, '{64'd0, 38'd0, 1'b0}},
    '{ROW_PAIR, '0, '0, COORD_MIN, COORD_MIN, 1'b0, NO_RESULT},
    '{ROW_PAIR, '0, '0, COORD_MAX, COORD_MAX, 1'b1, '{64'd0, 38'd0, 1'b0}},
    '{ROW_CFG, CFG_VECTOR_LENGTH, 8'd1, 16'sd0, 16'sd0, 1'b0, NO_RESULT},
    '{ROW_PAIR, '0, '0, COORD_MAX, COORD_MIN, 1'b1, '{EXT_SQ_KEY, EXT_SQ, 1'b0}},
    '{ROW_PAIR, '0, '0, COORD_MIN, COORD_MAX, 1'b1, '{EXT_SQ_KEY, EXT_SQ, 1'b0}},
    '{ROW_CFG, CFG_DISTANCE_MODE, 8'(MODE_ROOT), 16'sd0, 16'sd0, 1'b0, NO_RESULT},
    '{ROW_PAIR, '0, '0, COORD_MAX, COORD_MIN, 1'b1, '{64'd65535, EXT_SQ, 1'b0}},
    '{ROW_PAIR, '0, '0, 16'sd3, -16'sd1, 1'b1, '{64'd4, 38'd16, 1'b0}},
    '{ROW_CFG, CFG_DISTANCE_MODE, 8'(MODE_SQUARE), 16'sd0, 16'sd0, 1'b0, NO_RESULT},
    '{ROW_PAIR, '0, '0, COORD_MAX, COORD_MIN, 1'b0, NO_RESULT},
    '{ROW_PAIR, '0, '0, 16'sd1, 16'sd0, 1'b1, '{64'd1, 38'd1, 1'b0}},
    '{ROW_CFG, CFG_DISTANCE_MODE, 8'(MODE_CUBE), 16'sd0, 16'sd0, 1'b0, NO_RESULT},
    '{ROW_PAIR, '0, '0, COORD_MAX, COORD_MIN, 1'b1, '{KEY_CLAMP, EXT_SQ, 1'b1}},
    '{ROW_PAIR, '0, '0, -16'sd2, 16'sd0, 1'b1, '{64'd64, 38'd4, 1'b0}},
    '{ROW_CFG, CFG_DISTANCE_MODE, 8'(MODE_POW4), 16'sd0, 16'sd0, 1'b0, NO_RESULT},
    '{ROW_PAIR, '0, '0, 16'sd255, 16'sd0, 1'b0, NO_RESULT},
    '{ROW_PAIR, '0, '0, 16'sd256, 16'sd0, 1'b1, '{KEY_CLAMP, 38'd65536, 1'b1}},
    '{ROW_CFG, CFG_DISTANCE_MODE, 8'(MODE_SPARE_HI), 16'sd0, 16'sd0, 1'b0, NO_RESULT},
    '{ROW_PAIR, '0, '0, 16'sd1, -16'sd1, 1'b1, '{64'd256, 38'd4, 1'b0}},
    '{ROW_CFG, CFG_DISTANCE_MODE, 8'(MODE_SPARE_LO), 16'sd0, 16'sd0, 1'b0, NO_RESULT},
    '{ROW_PAIR, '0, '0, COORD_MAX, COORD_MIN, 1'b1, '{KEY_CLAMP, EXT_SQ, 1'b1}},
    '{ROW_CFG, CFG_VECTOR_LENGTH, 8'd0, 16'sd0, 16'sd0, 1'b0, NO_RESULT},
    '{ROW_CFG, CFG_DISTANCE_MODE, 8'(MODE_SUM), 16'sd0, 16'sd0, 1'b0, NO_RESULT},
    '{ROW_PAIR, '0, '0, 16'sd100, -16'sd100, 1'b1, '{64'd40000, 38'd40000, 1'b0}},
    '{ROW_CFG, CFG_VECTOR_LENGTH, 8'd4, 16'sd0, 16'sd0, 1'b0, NO_RESULT},
    '{ROW_PAIR, '0, '0, 16'sd1, 16'sd0, 1'b0, NO_RESULT},
    '{ROW_PAIR, '0, '0, 16'sd2, 16'sd0, 1'b0, NO_RESULT},
    '{ROW_PAIR, '0, '0, 16'sd3, 16'sd0, 1'b0, NO_RESULT},
    '{ROW_CFG, CFG_VECTOR_LENGTH, 8'd2, 16'sd0, 16'sd0, 1'b0, NO_RESULT},
    '{ROW_PAIR, '0, '0, 16'sd0, 16'sd0, 1'b1, '{64'd14, 38'd14, 1'b0}},
    '{ROW_CFG, CFG_SPARE_IDX, 8'hff, 16'sd0, 16'sd0, 1'b0, NO_RESULT},
    '{ROW_PAIR, '0, '0, 16'sd0, -16'sd5, 1'b0, NO_RESULT},
    '{ROW_PAIR, '0, '0, 16'sd5, 16'sd0, 1'b1, '{64'd50, 38'd50, 1'b0}}
  };

  logic clk   = 1'b0;
  logic rst_n = 1'b0;
  bit   calm  = 1'b0;

  int unsigned mismatch_count = 0;
  int unsigned quiet_cycles   = 0;

  // Predictor state: running sum, pair count and register copies
  logic [63:0]          acc_sum    = '0;
  int unsigned          pairs_seen = 0;
  logic [LEN_BITS-1:0]  cur_len    = LEN_RESET;
  logic [MODE_BITS-1:0] cur_mode   = MODE_RESET;

  dist_res_t pending_distances [$];

  kpow_in_if #(.COORD_BITS(COORD_BITS)) in_bus ();
  kpow_out_if                           out_bus ();
  kpow_cfg_if                           cfg_bus ();

  squared_distance_power_kernel_core #(
    .MAX_DIM    (MAX_DIM),
    .COORD_BITS (COORD_BITS)
  ) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_bus),
    .out_chan (out_bus),
    .cfg_chan (cfg_bus)
  );

  always #5 clk = ~clk;

  // Floor of the square root, one result bit at a time from the top
  function automatic logic [63:0] integer_root(input logic [63:0] n);
    logic [63:0] root;
    logic [63:0] trial;
    root = '0;
    for (int i = 31; i >= 0; i--) begin
      trial = root | (64'd1 << i);
      if (trial * trial <= n) root = trial;
    end
    return root;
  endfunction

  // Power of the sum, clamped to all ones once it leaves 64 bits; {sat, key}
  function automatic logic [64:0] clamped_power(input logic [63:0] base, input int n);
    logic [127:0] prod;
    prod = 128'(base);
    for (int i = 1; i < n; i++) begin
      prod = prod * 128'(base);
      if (prod[127:64] != '0) return {1'b1, KEY_CLAMP};
    end
    return {1'b0, prod[63:0]};
  endfunction

  // Accumulate one pair; on the closing pair build the result and clear
  task automatic predict_distance(input logic signed [COORD_BITS-1:0] a,
                                  input logic signed [COORD_BITS-1:0] b,
                                  output bit closes, output dist_res_t res);
    logic signed [COORD_BITS:0] diff;
    logic [COORD_BITS:0]        mag;
    logic [63:0]                sum;
    logic [64:0]                pow;
    int unsigned                eff_len;
    diff = a - b;
    mag  = (diff < 0) ? -diff : diff;
    sum  = acc_sum + 64'(mag) * 64'(mag);
    if (sum > 64'(SUM_MASK)) sum = 64'(SUM_MASK);
    eff_len = (cur_len == 0) ? 1 : (cur_len > MAX_DIM) ? MAX_DIM : cur_len;
    pairs_seen++;
    closes = (pairs_seen >= eff_len);
    res    = NO_RESULT;
    if (!closes) begin
      acc_sum = sum;
    end else begin
      res.sqd = sum[SUM_BITS-1:0];
      case (cur_mode)
        MODE_ROOT:   pow = {1'b0, integer_root(sum)};
        MODE_SUM:    pow = {1'b0, sum};
        MODE_SQUARE: pow = clamped_power(sum, 2);
        MODE_CUBE:   pow = clamped_power(sum, 3);
        default:     pow = clamped_power(sum, 4);
      endcase
      res.sat    = pow[64];
      res.key    = pow[63:0];
      acc_sum    = '0;
      pairs_seen = 0;
    end
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("[%0t] mismatch on %s: got 0x%0h, want 0x%0h", $time, what, got, want);
    mismatch_count++;
  endtask

  // Register write; valid stays up so that writes can run back to back
  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] data);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= data;
    do @(posedge clk); while (!cfg_bus.ready);
    if (idx == CFG_VECTOR_LENGTH) cur_len = data[LEN_BITS-1:0];
    else if (idx == CFG_DISTANCE_MODE) cur_mode = data[MODE_BITS-1:0];
  endtask

  // Send one coordinate request, with an occasional idle gap ahead of it
  task automatic push_pair(input logic signed [COORD_BITS-1:0] a,
                           input logic signed [COORD_BITS-1:0] b,
                           input bit typed, input dist_res_t typed_res);
    bit        closes;
    dist_res_t res;
    cfg_bus.valid <= 1'b0;
    if (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_bus.valid   <= 1'b1;
    in_bus.coord_a <= a;
    in_bus.coord_b <= b;
    do @(posedge clk); while (!in_bus.ready);
    predict_distance(a, b, closes, res);
    if (closes)
      pending_distances.insert(pending_distances.size(), typed ? typed_res : res);
  endtask

  // Hold the sender until every result is back, then let the block settle
  task automatic drain_pipeline(input int gap);
    in_bus.valid  <= 1'b0;
    cfg_bus.valid <= 1'b0;
    while (pending_distances.size() != 0) @(posedge clk);
    repeat (gap) @(posedge clk);
  endtask

  function automatic logic signed [COORD_BITS-1:0] extreme_coord();
    case ($urandom_range(3))
      0:       return COORD_MIN;
      1:       return COORD_MAX;
      2:       return 16'sd0;
      default: return -16'sd1;
    endcase
  endfunction

  // Result side back-pressure
  always @(posedge clk) begin
    out_bus.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
  end

  // Check each result against the oldest outstanding request
  always @(posedge clk) begin
    dist_res_t want;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (pending_distances.size() == 0) begin
        report_mismatch("result with no request outstanding", out_bus.ordering_key, '0);
      end else begin
        want = pending_distances.pop_front();
        if (out_bus.ordering_key !== want.key)
          report_mismatch("ordering_key", out_bus.ordering_key, want.key);
        if (out_bus.squared_distance !== want.sqd)
          report_mismatch("squared_distance", 64'(out_bus.squared_distance), 64'(want.sqd));
        if (out_bus.key_saturated !== want.sat)
          report_mismatch("key_saturated", 64'(out_bus.key_saturated), 64'(want.sat));
      end
    end
  end

  // Watchdog: end the run when no channel has moved for too long
  always @(posedge clk) begin
    if (!rst_n || (in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) ||
        (cfg_bus.valid && cfg_bus.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("[%0t] watchdog expired", $time);
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int unsigned                  phase;
    int unsigned                  random_sent;
    int unsigned                  burst;
    int unsigned                  large_left;
    int unsigned                  pick;
    logic [LEN_BITS-1:0]          len_val;
    logic [MODE_BITS-1:0]         mode_val;
    logic signed [COORD_BITS-1:0] ca;
    logic signed [COORD_BITS-1:0] cb;

    in_bus.valid   <= 1'b0;
    in_bus.coord_a <= '0;
    in_bus.coord_b <= '0;
    cfg_bus.valid  <= 1'b0;
    cfg_bus.index  <= '0;
    cfg_bus.data   <= '0;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed table
    foreach (directed_plan[i]) begin
      if (directed_plan[i].kind == ROW_CFG) begin
        drain_pipeline(DRAIN_GAP);
        write_reg(directed_plan[i].idx, directed_plan[i].data);
      end else begin
        push_pair(directed_plan[i].a, directed_plan[i].b, directed_plan[i].typed,
                  directed_plan[i].res);
      end
    end

    // Random phases: new settings on an idle block, then a burst of pairs
    phase       = 0;
    random_sent = 0;
    large_left  = 3;
    while (random_sent < RANDOM_ITEMS) begin
      drain_pipeline(DRAIN_GAP);
      calm = (phase >= 4 && phase < 8);
      pick = $urandom_range(99);
      if (phase == 0) begin
        len_val = LEN_BITS'(127);
      end else if (pick < 8 && large_left > 0) begin
        len_val = $urandom_range(1) ? LEN_BITS'(MAX_DIM) : LEN_BITS'($urandom_range(65, 126));
        large_left--;
      end else if (pick < 15) begin
        len_val = '0;
      end else if (pick < 75) begin
        len_val = LEN_BITS'($urandom_range(1, 4));
      end else begin
        len_val = LEN_BITS'($urandom_range(5, 12));
      end
      mode_val = MODE_BITS'($urandom_range(7));
      write_reg(CFG_VECTOR_LENGTH, {1'($urandom), len_val});
      write_reg(CFG_DISTANCE_MODE, {5'($urandom), mode_val});
      burst = (len_val >= 32) ? MAX_DIM + $urandom_range(0, 40) : $urandom_range(8, 40);
      repeat (burst) begin
        case ($urandom_range(4))
          0, 1: begin
            ca = COORD_BITS'($urandom);
            cb = COORD_BITS'($urandom);
          end
          2: begin
            ca = extreme_coord();
            cb = extreme_coord();
          end
          default: begin
            ca = COORD_BITS'($urandom_range(600)) - 16'sd300;
            cb = COORD_BITS'($urandom_range(600)) - 16'sd300;
          end
        endcase
        push_pair(ca, cb, 1'b0, NO_RESULT);
        random_sent++;
      end
      phase++;
    end

    // Wind down and give the verdict
    calm = 1'b0;
    drain_pipeline(SETTLE_GAP);
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
